@@ rtl/core/least_squares_line_fit_core_defines.svh @@
// assertion macros for the least squares line fit core
// used by the checker; expects i_clk and i_rst_n in the enclosing scope
`ifndef LEAST_SQUARES_LINE_FIT_CORE_DEFINES_SVH
`define LEAST_SQUARES_LINE_FIT_CORE_DEFINES_SVH

// consequent must hold in the same cycle
`define LSLF_ASSERT_NOW(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error("line fit check failed");

// consequent must hold in the following cycle
`define LSLF_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error("line fit check failed");

`endif

@@ rtl/core/lslf_pkg.sv @@
// shared types and constants for the least squares line fit core
// no dependencies
package lslf_pkg;

    // field widths
    localparam int unsigned COORD_W = 20;
    localparam int unsigned POINT_W = 2 * COORD_W;
    localparam int unsigned RES_W   = 32;

    // shared serial multiplier: operand magnitude and product widths
    localparam int unsigned MUL_W  = 52;
    localparam int unsigned OPND_W = MUL_W + 1;
    localparam int unsigned PROD_W = 2 * MUL_W + 2;

    // shared serial divider: dividend and divisor widths
    localparam int unsigned DIV_NW = 120;
    localparam int unsigned DIV_DW = 64;

    // fraction alignment of the quotients
    localparam int unsigned K_SHIFT   = 16;
    localparam int unsigned B_SHIFT   = 4;
    localparam int unsigned MSE_SHIFT = 40;

    // saturation limits as quotient magnitudes
    localparam logic [RES_W-1:0] CAP_POS = 32'h7FFF_FFFF;
    localparam logic [RES_W-1:0] CAP_NEG = 32'h8000_0000;
    localparam logic [RES_W-1:0] CAP_U   = 32'hFFFF_FFFF;

    // fit status codes
    localparam logic [1:0] FS_OK      = 2'd0;
    localparam logic [1:0] FS_TOO_FEW = 2'd1;
    localparam logic [1:0] FS_DEGEN   = 2'd2;
    localparam logic [1:0] FS_DROPPED = 2'd3;

    // product sequence steps
    localparam logic [2:0] STEP_N_SXX   = 3'd0;
    localparam logic [2:0] STEP_SX_SX   = 3'd1;
    localparam logic [2:0] STEP_N_SXY   = 3'd2;
    localparam logic [2:0] STEP_SX_SY   = 3'd3;
    localparam logic [2:0] STEP_SXX_SY  = 3'd4;
    localparam logic [2:0] STEP_SXY_SX  = 3'd5;

    typedef enum logic [4:0] {
        ST_ACC,
        ST_DRAIN,
        ST_PROD,
        ST_PWAIT,
        ST_CHK,
        ST_DIVK,
        ST_DKWAIT,
        ST_DIVB,
        ST_DBWAIT,
        ST_RD,
        ST_EX1,
        ST_EX2,
        ST_EMUL,
        ST_EWAIT,
        ST_DIVM,
        ST_DMWAIT,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic                     start;
        logic signed [OPND_W-1:0] a;
        logic signed [OPND_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
        logic [RES_W-1:0]  cap;
    } t_div_req;

    // magnitude of a signed product-width value
    function automatic logic [PROD_W-1:0] mag_prod(input logic signed [PROD_W-1:0] v);
        mag_prod = v[PROD_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

@@ rtl/core/lslf_point_ram.sv @@
// point store: one write port, one registered read port
// uses lslf_pkg for the point width
module lslf_point_ram #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = 6
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [ADDR_W-1:0]            i_wr_addr,
    input  logic [lslf_pkg::POINT_W-1:0] i_wr_data,
    input  logic                         i_rd_en,
    input  logic [ADDR_W-1:0]            i_rd_addr,
    output logic [lslf_pkg::POINT_W-1:0] o_rd_data
);

    logic [lslf_pkg::POINT_W-1:0] mem [DEPTH];
    logic [lslf_pkg::POINT_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/lslf_mul.sv @@
// shared shift-add multiplier, one multiplier bit per cycle, signed operands
// uses lslf_pkg for widths and the request struct
module lslf_mul (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lslf_pkg::t_mul_req                 i_req,
    output logic                               o_done,
    output logic signed [lslf_pkg::PROD_W-1:0] o_prod
);

    localparam int unsigned MW    = lslf_pkg::MUL_W;
    localparam int unsigned OW    = lslf_pkg::OPND_W;
    localparam int unsigned PW    = lslf_pkg::PROD_W;
    localparam int unsigned CNT_W = $clog2(MW + 1);

    logic             r_busy;
    logic             r_fin;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [MW-1:0]    r_mplr;
    logic [2*MW-1:0]  r_mcd;
    logic [2*MW-1:0]  r_acc;
    logic signed [PW-1:0] r_prod;

    logic [OW-1:0] n_a_neg;
    logic [OW-1:0] n_b_neg;
    logic [MW-1:0] n_a_mag;
    logic [MW-1:0] n_b_mag;
    logic [PW-1:0] n_prod_mag;

    // operand magnitudes
    always_comb begin
        n_a_neg    = ~i_req.a + 1'b1;
        n_b_neg    = ~i_req.b + 1'b1;
        n_a_mag    = i_req.a[OW-1] ? n_a_neg[MW-1:0] : i_req.a[MW-1:0];
        n_b_mag    = i_req.b[OW-1] ? n_b_neg[MW-1:0] : i_req.b[MW-1:0];
        n_prod_mag = {2'b00, r_acc};
    end

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MW - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // shift-add datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mplr <= n_a_mag;
            r_mcd  <= {{MW{1'b0}}, n_b_mag};
            r_acc  <= '0;
            r_neg  <= i_req.a[OW-1] ^ i_req.b[OW-1];
        end else if (r_busy) begin
            if (r_mplr[0]) begin
                r_acc <= r_acc + r_mcd;
            end
            r_mplr <= r_mplr >> 1;
            r_mcd  <= r_mcd << 1;
        end
        if (r_fin) begin
            r_prod <= $signed(r_neg ? (~n_prod_mag + 1'b1) : n_prod_mag);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

@@ rtl/core/lslf_div.sv @@
// shared restoring divider, one quotient bit per cycle, saturating quotient
// uses lslf_pkg for widths and the request struct
module lslf_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lslf_pkg::t_div_req             i_req,
    output logic                           o_done,
    output logic [lslf_pkg::RES_W-1:0]     o_quot
);

    localparam int unsigned NW    = lslf_pkg::DIV_NW;
    localparam int unsigned DW    = lslf_pkg::DIV_DW;
    localparam int unsigned RW    = lslf_pkg::RES_W;
    localparam int unsigned CNT_W = $clog2(NW + 1);

    logic             r_busy;
    logic             r_fin;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_num;
    logic [DW-1:0]    r_den;
    logic [DW-1:0]    r_rem;
    logic [RW-1:0]    r_q;
    logic [RW-1:0]    r_cap;
    logic             r_ovf;
    logic [RW-1:0]    r_res;

    logic [DW:0] n_rem2;
    logic [DW:0] n_diff;
    logic        n_ge;

    // trial subtract
    always_comb begin
        n_rem2 = {r_rem, r_num[NW-1]};
        n_diff = n_rem2 - {1'b0, r_den};
        n_ge   = n_rem2 >= {1'b0, r_den};
    end

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder, overflow kept sticky
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_cap <= i_req.cap;
            r_rem <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= n_ge ? n_diff[DW-1:0] : n_rem2[DW-1:0];
            r_q   <= {r_q[RW-2:0], n_ge};
            r_ovf <= r_ovf | r_q[RW-1];
        end
        if (r_fin) begin
            r_res <= (r_ovf || (r_q > r_cap)) ? r_cap : r_q;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_res;

endmodule

@@ rtl/core/least_squares_line_fit_core.sv @@
// least squares straight-line fit over a streamed set of points
// uses lslf_pkg, lslf_point_ram, lslf_mul and lslf_div
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata = point_x, point_y; tlast = last_point
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata = slope, intercept, mse; tuser = status
//
// points are taken one per cycle while a set is open; each stored point is
// written to the point memory and its products summed through a three-stage pipe.
// after the last word the summing pipe drains; then, for two or more stored points, six
// products on the shared shift-add multiplier, two or one divisions on the shared divider,
// then per stored point a memory read and one squaring, and a final division;
// s_axis_tready is low meanwhile.
// the result sits in an output register; the next set is taken while it waits.
// synchronous active-low reset clears sums, counts and flags; the memory is not cleared.
module least_squares_line_fit_core #(
    parameter int unsigned MAX_POINTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // point_x [19:0], point_y [39:20]
    input  logic        s_axis_tlast,   // last_point
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // slope [31:0], intercept [63:32], mean_sq_error [95:64]
    output logic [1:0]  m_axis_tuser    // fit_status [1:0]
);

    localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
    localparam int unsigned CW    = lslf_pkg::COORD_W;
    localparam int unsigned RW    = lslf_pkg::RES_W;
    localparam int unsigned OW    = lslf_pkg::OPND_W;
    localparam int unsigned PW    = lslf_pkg::PROD_W;
    localparam int unsigned NW    = lslf_pkg::DIV_NW;
    localparam int unsigned DW    = lslf_pkg::DIV_DW;
    localparam int unsigned SX_W  = CW + CNT_W;
    localparam int unsigned SQ_W  = 2 * CW + CNT_W;
    localparam int unsigned KX_W  = RW + CW;

    lslf_pkg::t_state r_state, n_state;

    // accumulation state
    logic [CNT_W-1:0]       r_count;
    logic                   r_drop;
    logic signed [SQ_W-1:0] r_sxx;
    logic signed [SX_W-1:0] r_sx;
    logic signed [SQ_W-1:0] r_sxy;
    logic signed [SX_W-1:0] r_sy;

    // summing pipe
    logic                   r_v1, r_v2;
    logic signed [CW-1:0]   r_x1, r_y1, r_x2, r_y2;
    logic signed [2*CW-1:0] r_xx2, r_xy2;

    // fit datapath
    logic [2:0]             r_step;
    logic signed [PW-1:0]   r_t, r_den, r_nk, r_nb;
    logic                   r_degen;
    logic signed [RW-1:0]   r_k, r_b;
    logic [RW-1:0]          r_mse;
    logic [1:0]             r_status;
    logic [IDX_W-1:0]       r_idx;
    logic signed [KX_W-1:0] r_kx;
    logic signed [CW-1:0]   r_ry;
    logic signed [OW-1:0]   r_e;
    logic [NW-1:0]          r_acc;

    // output register
    logic             r_out_valid;
    logic [RW-1:0]    r_out_k, r_out_b, r_out_mse;
    logic [1:0]       r_out_status;

    logic                   n_in_acc;
    logic                   n_room;
    logic                   n_load;
    logic                   n_last_pt;
    logic signed [CW-1:0]   n_in_x, n_in_y;
    logic [lslf_pkg::POINT_W-1:0] n_rd_data;
    logic signed [CW-1:0]   n_ram_x, n_ram_y;
    logic                   n_rd_en;
    logic [SX_W-1:0]        n_sx_neg;
    logic [SX_W-1:0]        n_sx_mag;
    lslf_pkg::t_mul_req     n_mul_req;
    lslf_pkg::t_div_req     n_div_req;
    logic                   mul_done, div_done;
    logic signed [PW-1:0]   mul_prod;
    logic [RW-1:0]          div_quot;

    // input unpacking and shared conditions
    always_comb begin
        n_in_x    = s_axis_tdata[CW-1:0];
        n_in_y    = s_axis_tdata[2*CW-1:CW];
        n_in_acc  = s_axis_tvalid && s_axis_tready;
        n_room    = r_count < CNT_W'(MAX_POINTS);
        n_load    = (r_state == lslf_pkg::ST_LOAD) && (!r_out_valid || m_axis_tready);
        n_last_pt = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;
        n_ram_x   = n_rd_data[CW-1:0];
        n_ram_y   = n_rd_data[2*CW-1:CW];
        n_sx_neg  = ~r_sx + 1'b1;
        n_sx_mag  = r_sx[SX_W-1] ? n_sx_neg : r_sx;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lslf_pkg::ST_ACC: begin
                if (n_in_acc && s_axis_tlast) n_state = lslf_pkg::ST_DRAIN;
            end
            lslf_pkg::ST_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = (r_count <= CNT_W'(1)) ? lslf_pkg::ST_LOAD : lslf_pkg::ST_PROD;
                end
            end
            lslf_pkg::ST_PROD:   n_state = lslf_pkg::ST_PWAIT;
            lslf_pkg::ST_PWAIT: begin
                if (mul_done) begin
                    n_state = (r_step == lslf_pkg::STEP_SXY_SX) ? lslf_pkg::ST_CHK
                                                                 : lslf_pkg::ST_PROD;
                end
            end
            lslf_pkg::ST_CHK: begin
                n_state = (r_den == '0) ? lslf_pkg::ST_DIVB : lslf_pkg::ST_DIVK;
            end
            lslf_pkg::ST_DIVK:   n_state = lslf_pkg::ST_DKWAIT;
            lslf_pkg::ST_DKWAIT: begin
                if (div_done) n_state = lslf_pkg::ST_DIVB;
            end
            lslf_pkg::ST_DIVB:   n_state = lslf_pkg::ST_DBWAIT;
            lslf_pkg::ST_DBWAIT: begin
                if (div_done) n_state = lslf_pkg::ST_RD;
            end
            lslf_pkg::ST_RD:     n_state = lslf_pkg::ST_EX1;
            lslf_pkg::ST_EX1:    n_state = lslf_pkg::ST_EX2;
            lslf_pkg::ST_EX2:    n_state = lslf_pkg::ST_EMUL;
            lslf_pkg::ST_EMUL:   n_state = lslf_pkg::ST_EWAIT;
            lslf_pkg::ST_EWAIT: begin
                if (mul_done) n_state = n_last_pt ? lslf_pkg::ST_DIVM : lslf_pkg::ST_RD;
            end
            lslf_pkg::ST_DIVM:   n_state = lslf_pkg::ST_DMWAIT;
            lslf_pkg::ST_DMWAIT: begin
                if (div_done) n_state = lslf_pkg::ST_LOAD;
            end
            lslf_pkg::ST_LOAD: begin
                if (n_load) n_state = lslf_pkg::ST_ACC;
            end
            default:             n_state = lslf_pkg::ST_ACC;
        endcase
    end

    // state outputs: handshake, memory read, unit requests
    always_comb begin
        s_axis_tready   = (r_state == lslf_pkg::ST_ACC);
        n_rd_en         = (r_state == lslf_pkg::ST_RD);
        n_mul_req.start = (r_state == lslf_pkg::ST_PROD) || (r_state == lslf_pkg::ST_EMUL);
        n_mul_req.a     = r_e;
        n_mul_req.b     = r_e;
        n_div_req.start = (r_state == lslf_pkg::ST_DIVK) || (r_state == lslf_pkg::ST_DIVB)
                          || (r_state == lslf_pkg::ST_DIVM);
        n_div_req.num   = '0;
        n_div_req.den   = '0;
        n_div_req.cap   = lslf_pkg::CAP_U;
        if (r_state == lslf_pkg::ST_PROD) begin
            case (r_step)
                lslf_pkg::STEP_N_SXX: begin
                    n_mul_req.a = OW'({1'b0, r_count});
                    n_mul_req.b = OW'(r_sxx);
                end
                lslf_pkg::STEP_SX_SX: begin
                    n_mul_req.a = OW'(r_sx);
                    n_mul_req.b = OW'(r_sx);
                end
                lslf_pkg::STEP_N_SXY: begin
                    n_mul_req.a = OW'({1'b0, r_count});
                    n_mul_req.b = OW'(r_sxy);
                end
                lslf_pkg::STEP_SX_SY: begin
                    n_mul_req.a = OW'(r_sx);
                    n_mul_req.b = OW'(r_sy);
                end
                lslf_pkg::STEP_SXX_SY: begin
                    n_mul_req.a = OW'(r_sxx);
                    n_mul_req.b = OW'(r_sy);
                end
                lslf_pkg::STEP_SXY_SX: begin
                    n_mul_req.a = OW'(r_sxy);
                    n_mul_req.b = OW'(r_sx);
                end
                default: begin
                    n_mul_req.a = '0;
                    n_mul_req.b = '0;
                end
            endcase
        end
        case (r_state)
            lslf_pkg::ST_DIVK: begin
                n_div_req.num = NW'(lslf_pkg::mag_prod(r_nk)) << lslf_pkg::K_SHIFT;
                n_div_req.den = r_den[DW-1:0];
                n_div_req.cap = r_nk[PW-1] ? lslf_pkg::CAP_NEG : lslf_pkg::CAP_POS;
            end
            lslf_pkg::ST_DIVB: begin
                if (r_degen) begin
                    n_div_req.num = NW'(n_sx_mag) << lslf_pkg::B_SHIFT;
                    n_div_req.den = DW'(r_count);
                    n_div_req.cap = r_sx[SX_W-1] ? lslf_pkg::CAP_NEG : lslf_pkg::CAP_POS;
                end else begin
                    n_div_req.num = NW'(lslf_pkg::mag_prod(r_nb)) << lslf_pkg::B_SHIFT;
                    n_div_req.den = r_den[DW-1:0];
                    n_div_req.cap = r_nb[PW-1] ? lslf_pkg::CAP_NEG : lslf_pkg::CAP_POS;
                end
            end
            lslf_pkg::ST_DIVM: begin
                n_div_req.num = r_acc;
                n_div_req.den = DW'(r_count) << lslf_pkg::MSE_SHIFT;
                n_div_req.cap = lslf_pkg::CAP_U;
            end
            default: begin
                n_div_req.num = '0;
            end
        endcase
    end

    // control state, sums and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lslf_pkg::ST_ACC;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_sxx       <= '0;
            r_sx        <= '0;
            r_sxy       <= '0;
            r_sy        <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_step      <= lslf_pkg::STEP_N_SXX;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= n_in_acc && n_room;
            r_v2    <= r_v1;
            // count stored words, flag those beyond capacity
            if (n_in_acc) begin
                if (n_room) r_count <= r_count + 1'b1;
                else        r_drop  <= 1'b1;
            end
            if (r_v2) begin
                r_sxx <= r_sxx + SQ_W'(r_xx2);
                r_sx  <= r_sx + SX_W'(r_x2);
                r_sxy <= r_sxy + SQ_W'(r_xy2);
                r_sy  <= r_sy + SX_W'(r_y2);
            end
            if (r_state == lslf_pkg::ST_DRAIN) r_step <= lslf_pkg::STEP_N_SXX;
            if ((r_state == lslf_pkg::ST_PWAIT) && mul_done) r_step <= r_step + 1'b1;
            if ((r_state == lslf_pkg::ST_DBWAIT) && div_done) r_idx <= '0;
            if ((r_state == lslf_pkg::ST_EWAIT) && mul_done) r_idx <= r_idx + 1'b1;
            // output word and clearing for the next set
            if (n_load) begin
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_drop      <= 1'b0;
                r_sxx       <= '0;
                r_sx        <= '0;
                r_sxy       <= '0;
                r_sy        <= '0;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload datapath
    always_ff @(posedge i_clk) begin
        r_x1  <= n_in_x;
        r_y1  <= n_in_y;
        r_x2  <= r_x1;
        r_y2  <= r_y1;
        r_xx2 <= r_x1 * r_x1;
        r_xy2 <= r_x1 * r_y1;
        case (r_state)
            lslf_pkg::ST_DRAIN: begin
                r_k      <= '0;
                r_b      <= '0;
                r_mse    <= '0;
                r_status <= lslf_pkg::FS_TOO_FEW;
            end
            lslf_pkg::ST_PWAIT: begin
                if (mul_done) begin
                    case (r_step)
                        lslf_pkg::STEP_SX_SX:  r_den <= r_t - mul_prod;
                        lslf_pkg::STEP_SX_SY:  r_nk  <= r_t - mul_prod;
                        lslf_pkg::STEP_SXY_SX: r_nb  <= r_t - mul_prod;
                        default:               r_t   <= mul_prod;
                    endcase
                end
            end
            lslf_pkg::ST_CHK: begin
                r_degen <= (r_den == '0);
                if (r_den == '0) begin
                    r_k      <= '0;
                    r_status <= lslf_pkg::FS_DEGEN;
                end else begin
                    r_status <= r_drop ? lslf_pkg::FS_DROPPED : lslf_pkg::FS_OK;
                end
            end
            lslf_pkg::ST_DKWAIT: begin
                if (div_done) r_k <= r_nk[PW-1] ? (~div_quot + 1'b1) : div_quot;
            end
            lslf_pkg::ST_DBWAIT: begin
                if (div_done) begin
                    if (r_degen ? r_sx[SX_W-1] : r_nb[PW-1]) r_b <= ~div_quot + 1'b1;
                    else                                     r_b <= div_quot;
                end
                r_acc <= '0;
            end
            // residual in q.16: k*x + b*4096 - y*65536
            lslf_pkg::ST_EX1: begin
                r_kx <= r_k * n_ram_x;
                r_ry <= n_ram_y;
            end
            lslf_pkg::ST_EX2: begin
                r_e <= OW'(r_kx) + (OW'(r_b) <<< 12) - (OW'(r_ry) <<< 16);
            end
            lslf_pkg::ST_EWAIT: begin
                if (mul_done) r_acc <= r_acc + NW'($unsigned(mul_prod));
            end
            lslf_pkg::ST_DMWAIT: begin
                if (div_done) r_mse <= div_quot;
            end
            default: begin
                r_kx <= r_kx;
            end
        endcase
        if (n_load) begin
            r_out_k      <= r_k;
            r_out_b      <= r_b;
            r_out_mse    <= r_mse;
            r_out_status <= r_status;
        end
    end

    lslf_point_ram #(
        .DEPTH  (MAX_POINTS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (n_in_acc && n_room),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (s_axis_tdata[lslf_pkg::POINT_W-1:0]),
        .i_rd_en   (n_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (n_rd_data)
    );

    lslf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_mul_req),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    lslf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_mse, r_out_b, r_out_k};
    assign m_axis_tuser  = r_out_status;

endmodule

@@ rtl/core/lslf_checker.sv @@
// port-level checks for the least squares line fit core, bound to the top level
// uses lslf_pkg status codes and the assertion macros header
`include "least_squares_line_fit_core_defines.svh"

module lslf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result word holds
    `LSLF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // closing a set stops intake while the fit runs
    `LSLF_ASSERT_NEXT(a_last_stops_intake, s_axis_tvalid && s_axis_tready && s_axis_tlast,
                      !s_axis_tready)

    // too few points gives an all-zero fit
    `LSLF_ASSERT_NOW(a_too_few_zero, m_axis_tvalid && (m_axis_tuser == lslf_pkg::FS_TOO_FEW),
                     m_axis_tdata == '0)

    // degenerate fit has zero slope
    `LSLF_ASSERT_NOW(a_degen_flat, m_axis_tvalid && (m_axis_tuser == lslf_pkg::FS_DEGEN),
                     m_axis_tdata[31:0] == '0)

endmodule

bind least_squares_line_fit_core lslf_checker u_lslf_checker (.*);
